// ----- rtl/wavhp_pkg.sv -----
package wavhp_pkg;

  // result status codes
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_NOT_WAV    = 2'd1;
  localparam logic [1:0] STATUS_CORRUPTED  = 2'd2;
  localparam logic [1:0] STATUS_ZERO_ALIGN = 2'd3;

  // tags as they sit in the little-endian shift word
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_CHUNK_SIZE = 32'd16;
  localparam logic [32:0] SIZE_ADD       = 33'd8;

  // byte positions within the header
  localparam logic [5:0] POS_RIFF_TAG  = 6'd3;
  localparam logic [5:0] POS_RIFF_SIZE = 6'd7;
  localparam logic [5:0] POS_WAVE_TAG  = 6'd11;
  localparam logic [5:0] POS_FMT_TAG   = 6'd15;
  localparam logic [5:0] POS_FMT_SIZE  = 6'd19;
  localparam logic [5:0] POS_FORMAT    = 6'd21;
  localparam logic [5:0] POS_CHANNELS  = 6'd23;
  localparam logic [5:0] POS_RATE      = 6'd27;
  localparam logic [5:0] POS_ALIGN     = 6'd33;
  localparam logic [5:0] POS_DATA_TAG  = 6'd39;
  localparam logic [5:0] POS_LAST      = 6'd43;

  localparam int DIV_STEPS = 32;

  // one parsed header, handed from front to back
  typedef struct packed {
    logic [1:0]  status;
    logic [32:0] file_size;
    logic [15:0] audio_format;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] block_align;
    logic [31:0] data_size;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_OUT
  } back_state_t;

endpackage

// ----- rtl/wavhp_front.sv -----
module wavhp_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_vld,
  input  logic [7:0]       data_byte,
  input  logic             first_byte,
  output logic             push,
  output wavhp_pkg::job_t  push_job
);

  logic [5:0]  pos_r, pos_nxt;
  logic        finished_r, finished_nxt;
  logic [31:0] last_four_r, last_four_nxt;
  logic [31:0] riff_size_r, riff_size_nxt;
  logic [15:0] format_r, format_nxt;
  logic [15:0] channels_r, channels_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] align_r, align_nxt;

  logic        active;
  logic [5:0]  pos;
  logic [31:0] lf_base;
  logic [32:0] file_size_all;
  logic [1:0]  err_status;
  logic        size_known;

  assign active        = byte_vld && (first_byte || !finished_r);
  assign pos           = first_byte ? 6'd0 : pos_r;
  assign lf_base       = first_byte ? 32'd0 : last_four_r;
  assign last_four_nxt = {data_byte, lf_base[31:8]};
  assign file_size_all = {1'b0, riff_size_r} + wavhp_pkg::SIZE_ADD;

  always_comb begin
    pos_nxt       = pos_r;
    finished_nxt  = finished_r;
    riff_size_nxt = riff_size_r;
    format_nxt    = format_r;
    channels_nxt  = channels_r;
    rate_nxt      = rate_r;
    align_nxt     = align_r;
    push          = 1'b0;
    err_status    = wavhp_pkg::STATUS_OK;
    size_known    = 1'b1;
    if (active) begin
      pos_nxt      = pos + 6'd1;
      finished_nxt = 1'b0;
      if (first_byte) begin
        riff_size_nxt = '0;
        format_nxt    = '0;
        channels_nxt  = '0;
        rate_nxt      = '0;
        align_nxt     = '0;
      end
      unique case (pos)
        wavhp_pkg::POS_RIFF_TAG: begin
          if (last_four_nxt != wavhp_pkg::TAG_RIFF) begin
            push       = 1'b1;
            err_status = wavhp_pkg::STATUS_NOT_WAV;
            size_known = 1'b0;
          end
        end
        wavhp_pkg::POS_RIFF_SIZE: riff_size_nxt = last_four_nxt;
        wavhp_pkg::POS_WAVE_TAG: begin
          if (last_four_nxt != wavhp_pkg::TAG_WAVE) begin
            push       = 1'b1;
            err_status = wavhp_pkg::STATUS_NOT_WAV;
          end
        end
        wavhp_pkg::POS_FMT_TAG: begin
          if (last_four_nxt != wavhp_pkg::TAG_FMT) begin
            push       = 1'b1;
            err_status = wavhp_pkg::STATUS_CORRUPTED;
          end
        end
        wavhp_pkg::POS_FMT_SIZE: begin
          if (last_four_nxt != wavhp_pkg::FMT_CHUNK_SIZE) begin
            push       = 1'b1;
            err_status = wavhp_pkg::STATUS_CORRUPTED;
          end
        end
        wavhp_pkg::POS_FORMAT:   format_nxt   = last_four_nxt[31:16];
        wavhp_pkg::POS_CHANNELS: channels_nxt = last_four_nxt[31:16];
        wavhp_pkg::POS_RATE:     rate_nxt     = last_four_nxt;
        wavhp_pkg::POS_ALIGN:    align_nxt    = last_four_nxt[31:16];
        wavhp_pkg::POS_DATA_TAG: begin
          if (last_four_nxt != wavhp_pkg::TAG_DATA) begin
            push       = 1'b1;
            err_status = wavhp_pkg::STATUS_CORRUPTED;
          end
        end
        wavhp_pkg::POS_LAST: begin
          push       = 1'b1;
          err_status = (align_r == 16'd0) ? wavhp_pkg::STATUS_ZERO_ALIGN
                                          : wavhp_pkg::STATUS_OK;
        end
        default: ;
      endcase
      if (push) begin
        finished_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    push_job.status        = err_status;
    push_job.file_size     = size_known ? file_size_all : 33'd0;
    push_job.audio_format  = format_r;
    push_job.channel_count = channels_r;
    push_job.sample_rate   = rate_r;
    push_job.block_align   = align_r;
    push_job.data_size     = last_four_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      finished_r  <= 1'b1;
      last_four_r <= '0;
      riff_size_r <= '0;
      format_r    <= '0;
      channels_r  <= '0;
      rate_r      <= '0;
      align_r     <= '0;
    end else begin
      pos_r      <= pos_nxt;
      finished_r <= finished_nxt;
      if (active) begin
        last_four_r <= last_four_nxt;
      end
      riff_size_r <= riff_size_nxt;
      format_r    <= format_nxt;
      channels_r  <= channels_nxt;
      rate_r      <= rate_nxt;
      align_r     <= align_nxt;
    end
  end

endmodule

// ----- rtl/wavhp_queue.sv -----
module wavhp_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  wavhp_pkg::job_t  push_job,
  output logic             full,
  output logic             not_empty,
  input  logic             pop,
  output wavhp_pkg::job_t  pop_job
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  wavhp_pkg::job_t  slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_job   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/wavhp_back.sv -----
module wavhp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_vld,
  input  wavhp_pkg::job_t  job_in,
  output logic             job_pop,
  output logic             res_vld,
  input  logic             res_stall,
  output wavhp_pkg::job_t  res_job,
  output logic [31:0]      res_count
);

  localparam int STEP_W = $clog2(wavhp_pkg::DIV_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(wavhp_pkg::DIV_STEPS - 1);

  wavhp_pkg::back_state_t state_r, state_nxt;
  wavhp_pkg::job_t        job_r;
  logic [31:0]            quot_r;
  logic [15:0]            rem_r;
  logic [STEP_W-1:0]      step_r;

  logic [16:0] shifted;
  logic        ge;
  logic [16:0] diff;

  // restoring division, one quotient bit a cycle
  assign shifted = {rem_r, quot_r[31]};
  assign ge      = (shifted >= {1'b0, job_r.block_align});
  assign diff    = shifted - {1'b0, job_r.block_align};

  always_comb begin
    state_nxt = state_r;
    job_pop   = 1'b0;
    res_vld   = 1'b0;
    unique case (state_r)
      wavhp_pkg::BK_IDLE: begin
        if (job_vld) begin
          job_pop   = 1'b1;
          state_nxt = (job_in.status == wavhp_pkg::STATUS_OK) ? wavhp_pkg::BK_DIV
                                                              : wavhp_pkg::BK_OUT;
        end
      end
      wavhp_pkg::BK_DIV: begin
        if (step_r == LAST_STEP) begin
          state_nxt = wavhp_pkg::BK_OUT;
        end
      end
      wavhp_pkg::BK_OUT: begin
        res_vld = 1'b1;
        if (!res_stall) begin
          state_nxt = wavhp_pkg::BK_IDLE;
        end
      end
      default: state_nxt = wavhp_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wavhp_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r  <= job_in;
      quot_r <= (job_in.status == wavhp_pkg::STATUS_OK) ? job_in.data_size : 32'd0;
      rem_r  <= '0;
      step_r <= '0;
    end else if (state_r == wavhp_pkg::BK_DIV) begin
      quot_r <= {quot_r[30:0], ge};
      rem_r  <= ge ? diff[15:0] : shifted[15:0];
      step_r <= step_r + STEP_W'(1);
    end
  end

  assign res_job   = job_r;
  assign res_count = quot_r;

endmodule

// ----- rtl/wav_header_parser_core.sv -----
// wav header parser: takes a file one byte per item on the in_ channel, with
// in_first_byte marking the start of a new file, and checks the fixed 44-byte
// little-endian RIFF/WAVE PCM header as it streams past. at most one result
// item leaves on the out_ channel per file, either at the first failing tag or
// size check (status not wav or corrupted, fields not yet seen read as zero)
// or at the last header byte (status ok, or zero block align). bytes after the
// result, and bytes before any first byte, are dropped; a new first byte in
// mid-header abandons the old file with no result. the front end takes one
// byte every cycle while in_stall is low and hands each finished header to
// a small queue; the back end works out sample_count = data size / block
// align with a shift-subtract divider, one quotient bit per cycle. an ok
// header goes from idle through the divider state to the output state, an
// error or zero block align result from idle straight to the output state.
// in_stall rises only while the queue is full, which happens when results
// come faster than the back end can hand them out (short or broken files,
// or a long hold on out_stall); else a file is taken at one byte per cycle.
// QUEUE_DEPTH must be 2 or more.
module wav_header_parser_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte stream in
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  // header result out
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [32:0] out_file_size,
  output logic [15:0] out_audio_format,
  output logic [15:0] out_channel_count,
  output logic [31:0] out_sample_rate,
  output logic [15:0] out_block_align,
  output logic [31:0] out_sample_count
);

  logic            in_accept;
  logic            push;
  wavhp_pkg::job_t push_job;
  logic            q_full;
  logic            q_not_empty;
  logic            q_pop;
  wavhp_pkg::job_t q_job;
  wavhp_pkg::job_t res_job;
  logic [31:0]     res_count;

  // a full queue holds the byte stream back
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  // front: byte position tracking, tag checks and field capture
  wavhp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_vld   (in_accept),
    .data_byte  (in_data_byte),
    .first_byte (in_first_byte),
    .push       (push),
    .push_job   (push_job)
  );

  // parsed headers waiting for the divider
  wavhp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .pop_job   (q_job)
  );

  // back: sample count division and output register
  wavhp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_vld   (q_not_empty),
    .job_in    (q_job),
    .job_pop   (q_pop),
    .res_vld   (out_valid),
    .res_stall (out_stall),
    .res_job   (res_job),
    .res_count (res_count)
  );

  assign out_status        = res_job.status;
  assign out_file_size     = res_job.file_size;
  assign out_audio_format  = res_job.audio_format;
  assign out_channel_count = res_job.channel_count;
  assign out_sample_rate   = res_job.sample_rate;
  assign out_block_align   = res_job.block_align;
  assign out_sample_count  = res_count;

endmodule

// ----- sim/tb.sv -----
module tb;

  // ascii tags as they build up in the shift word, first byte in the low lane
  localparam logic [31:0] RIFF_WORD = "FFIR";
  localparam logic [31:0] WAVE_WORD = "EVAW";
  localparam logic [31:0] FMT_WORD  = " tmf";
  localparam logic [31:0] DATA_WORD = "atad";
  localparam int HDR_BYTES = 44;
  localparam int NO_FAULT  = -1;
  localparam int HOLD_CYCLES = 200;
  localparam int ITEMS_TARGET = 900;

  // one parsed header as it leaves the block
  typedef struct packed {
    logic [1:0]  status;
    logic [32:0] file_size;
    logic [15:0] audio_format;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] block_align;
    logic [31:0] sample_count;
  } hdr_result_t;

  // one file to stream in: header fields, an optional damaged byte,
  // how many bytes to send and how much loose junk goes ahead of it
  typedef struct {
    logic [31:0] riff_size;
    logic [31:0] fmt_size;
    logic [15:0] format;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [15:0] align;
    logic [31:0] dsize;
    int          bad_pos;
    logic [7:0]  bad_val;
    int          len;
    int          junk;
    bit          typed;
    hdr_result_t res;
  } hdr_case_t;

  typedef logic [HDR_BYTES-1:0][7:0] hdr_bytes_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_first_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [32:0] out_file_size;
  logic [15:0] out_audio_format;
  logic [15:0] out_channel_count;
  logic [31:0] out_sample_rate;
  logic [15:0] out_block_align;
  logic [31:0] out_sample_count;

  wav_header_parser_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_first_byte     (in_first_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_file_size     (out_file_size),
    .out_audio_format  (out_audio_format),
    .out_channel_count (out_channel_count),
    .out_sample_rate   (out_sample_rate),
    .out_block_align   (out_block_align),
    .out_sample_count  (out_sample_count)
  );

  always #1 clk = ~clk;

  // headers still owed by the block, oldest first
  hdr_result_t hdr_due_q[$];
  int fault_cnt = 0;
  int items_sent = 0;

  // random idling on both sides, and the long receiver hold-off request
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int hold_left = 0;

  // typed-in expectation that stands in for the parser's own for one file
  bit typed_on = 1'b0;
  hdr_result_t typed_res;

  // parser mirror: starts finished, so bytes before any first byte are dropped
  logic [5:0]  p_pos = '0;
  bit          p_done = 1'b1;
  logic [31:0] p_riff = '0;
  logic [31:0] p_fmt = '0;
  logic [15:0] p_format = '0;
  logic [15:0] p_chans = '0;
  logic [31:0] p_rate = '0;
  logic [15:0] p_align = '0;
  logic [31:0] p_dsize = '0;
  logic [31:0] p_shift = '0;

  // step the mirror by one byte
  task automatic wav_parse_byte(input logic [7:0] b, input logic f,
                                output bit got, output hdr_result_t r);
    logic [5:0]  at;
    bit          emit;
    logic [1:0]  st;
    logic [31:0] cnt;
    got  = 1'b0;
    r    = '0;
    emit = 1'b0;
    st   = wavhp_pkg::STATUS_OK;
    cnt  = '0;
    if (f) begin
      // new file: forget everything from the old one
      p_pos = '0;
      p_riff = '0;
      p_fmt = '0;
      p_format = '0;
      p_chans = '0;
      p_rate = '0;
      p_align = '0;
      p_dsize = '0;
      p_shift = '0;
      p_done = 1'b0;
    end else if (p_done) begin
      return;
    end
    at = p_pos;
    p_shift = {b, p_shift[31:8]};
    p_pos = at + 6'd1;
    case (at)
      wavhp_pkg::POS_RIFF_TAG: begin
        if (p_shift != RIFF_WORD) begin
          emit = 1'b1;
          st = wavhp_pkg::STATUS_NOT_WAV;
        end
      end
      wavhp_pkg::POS_RIFF_SIZE: p_riff = p_shift;
      wavhp_pkg::POS_WAVE_TAG: begin
        if (p_shift != WAVE_WORD) begin
          emit = 1'b1;
          st = wavhp_pkg::STATUS_NOT_WAV;
        end
      end
      wavhp_pkg::POS_FMT_TAG: begin
        if (p_shift != FMT_WORD) begin
          emit = 1'b1;
          st = wavhp_pkg::STATUS_CORRUPTED;
        end
      end
      wavhp_pkg::POS_FMT_SIZE: begin
        p_fmt = p_shift;
        if (p_fmt != 32'd16) begin
          emit = 1'b1;
          st = wavhp_pkg::STATUS_CORRUPTED;
        end
      end
      wavhp_pkg::POS_FORMAT:   p_format = p_shift[31:16];
      wavhp_pkg::POS_CHANNELS: p_chans = p_shift[31:16];
      wavhp_pkg::POS_RATE:     p_rate = p_shift;
      wavhp_pkg::POS_ALIGN:    p_align = p_shift[31:16];
      wavhp_pkg::POS_DATA_TAG: begin
        if (p_shift != DATA_WORD) begin
          emit = 1'b1;
          st = wavhp_pkg::STATUS_CORRUPTED;
        end
      end
      wavhp_pkg::POS_LAST: begin
        p_dsize = p_shift;
        emit = 1'b1;
        if (p_align == 16'd0) begin
          st = wavhp_pkg::STATUS_ZERO_ALIGN;
        end else begin
          cnt = p_dsize / {16'd0, p_align};
        end
      end
      default: ;
    endcase
    if (emit) begin
      got = 1'b1;
      p_done = 1'b1;
      r.status = st;
      // the size is unknown only when the very first tag fails
      r.file_size = (at == wavhp_pkg::POS_RIFF_TAG) ? 33'd0 : {1'b0, p_riff} + 33'd8;
      r.audio_format = p_format;
      r.channel_count = p_chans;
      r.sample_rate = p_rate;
      r.block_align = p_align;
      r.sample_count = cnt;
    end
  endtask

  function automatic hdr_result_t mk_res(input logic [1:0] st, input logic [32:0] fsize,
                                         input logic [15:0] fmt, input logic [15:0] ch,
                                         input logic [31:0] rate, input logic [15:0] align,
                                         input logic [31:0] cnt);
    hdr_result_t r;
    r = {st, fsize, fmt, ch, rate, align, cnt};
    return r;
  endfunction

  // lay the 44 header bytes out little-endian, byte rate and bit depth random
  function automatic hdr_bytes_t build_header(input hdr_case_t c);
    hdr_bytes_t h;
    h[3:0]   = RIFF_WORD;
    h[7:4]   = c.riff_size;
    h[11:8]  = WAVE_WORD;
    h[15:12] = FMT_WORD;
    h[19:16] = c.fmt_size;
    h[21:20] = c.format;
    h[23:22] = c.chans;
    h[27:24] = c.rate;
    h[31:28] = $urandom;
    h[33:32] = c.align;
    h[35:34] = 16'($urandom);
    h[39:36] = DATA_WORD;
    h[43:40] = c.dsize;
    if (c.bad_pos >= 0 && c.bad_pos < HDR_BYTES) h[c.bad_pos] = c.bad_val;
    return h;
  endfunction

  function automatic hdr_case_t rand_case();
    hdr_case_t c;
    int kind;
    kind = $urandom_range(99);
    c.riff_size = ($urandom_range(3) == 0) ? $urandom : 32'd36 + $urandom_range(4096);
    c.fmt_size = 32'd16;
    if (kind >= 85) c.fmt_size = ($urandom_range(2) == 0) ? $urandom : $urandom_range(32);
    c.format = $urandom_range(1) ? 16'd1 : 16'($urandom);
    c.chans = $urandom_range(1) ? 16'($urandom_range(1, 8)) : 16'($urandom);
    c.rate = $urandom;
    case ($urandom_range(9))
      0:       c.align = 16'd0;
      1, 2:    c.align = 16'($urandom);
      default: c.align = 16'($urandom_range(1, 16));
    endcase
    c.dsize = $urandom_range(1) ? $urandom : $urandom_range(4096);
    c.bad_pos = (kind >= 60 && kind < 75) ? $urandom_range(HDR_BYTES - 1) : NO_FAULT;
    c.bad_val = 8'($urandom);
    if (kind >= 75 && kind < 85) c.len = $urandom_range(1, HDR_BYTES - 1);
    else c.len = HDR_BYTES + (($urandom_range(3) == 0) ? $urandom_range(1, 8) : 0);
    c.junk = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : 0;
    c.typed = 1'b0;
    c.res = '0;
    return c;
  endfunction

  // offer one item; the mirror steps as it goes out, since an offered item
  // is held until taken
  task automatic push_byte(input logic [7:0] b, input logic f);
    bit got;
    hdr_result_t r;
    while (idle_on && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    wav_parse_byte(b, f, got, r);
    items_sent++;
    if (got) begin
      hdr_due_q.push_back(typed_on ? typed_res : r);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_first_byte <= f;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_file(input hdr_case_t c);
    hdr_bytes_t h;
    h = build_header(c);
    repeat (c.junk) push_byte(8'($urandom), 1'b0);
    typed_on = c.typed;
    typed_res = c.res;
    for (int i = 0; i < c.len; i++) begin
      push_byte((i < HDR_BYTES) ? h[i] : 8'($urandom), i == 0);
    end
    typed_on = 1'b0;
  endtask

  // stop offering, then wait until every owed header is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (hdr_due_q.size() != 0) @(negedge clk);
  endtask

  hdr_case_t hdr_table[$];

  task automatic add_row(input logic [31:0] riff, input logic [31:0] fmtsz,
                         input logic [15:0] format, input logic [15:0] chans,
                         input logic [31:0] rate, input logic [15:0] align,
                         input logic [31:0] dsize, input int bad_pos, input logic [7:0] bad_val,
                         input int len, input int junk, input bit typed,
                         input hdr_result_t res);
    hdr_case_t c;
    c.riff_size = riff;
    c.fmt_size = fmtsz;
    c.format = format;
    c.chans = chans;
    c.rate = rate;
    c.align = align;
    c.dsize = dsize;
    c.bad_pos = bad_pos;
    c.bad_val = bad_val;
    c.len = len;
    c.junk = junk;
    c.typed = typed;
    c.res = res;
    hdr_table.push_back(c);
  endtask

  // receiver: random stalls, or a long counted hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < 36);
      end
    end
  end

  task automatic check_field(input string what, input logic [32:0] want, input logic [32:0] seen);
    if (want !== seen) begin
      fault_cnt++;
      if (fault_cnt <= 10) $display("mismatch on %s: expected %0h, got %0h", what, want, seen);
    end
  endtask

  // result checker: every taken header against the oldest one owed
  always @(posedge clk) begin
    hdr_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (hdr_due_q.size() == 0) begin
        fault_cnt++;
        if (fault_cnt <= 10) $display("header result with none outstanding, status %0d", out_status);
      end else begin
        want = hdr_due_q.pop_front();
        check_field("status", 33'(want.status), 33'(out_status));
        check_field("file_size", want.file_size, out_file_size);
        check_field("audio_format", 33'(want.audio_format), 33'(out_audio_format));
        check_field("channel_count", 33'(want.channel_count), 33'(out_channel_count));
        check_field("sample_rate", 33'(want.sample_rate), 33'(out_sample_rate));
        check_field("block_align", 33'(want.block_align), 33'(out_block_align));
        check_field("sample_count", 33'(want.sample_count), 33'(out_sample_count));
      end
    end
  end

  // overall time limit
  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

  initial begin
    hdr_case_t c;
    int file_no;
    // directed files: riff, fmt size, format, channels, rate, align, data size,
    // damaged byte, its value, bytes sent, junk ahead, typed, expected header
    // plain pcm after loose bytes that arrive before any first byte
    add_row(36, 16, 1, 2, 44100, 4, 1000, NO_FAULT, 0, 44, 3, 1,
            mk_res(wavhp_pkg::STATUS_OK, 44, 1, 2, 44100, 4, 250));
    // every field at its top value, biggest possible file size
    add_row('1, 16, '1, '1, '1, '1, '1, NO_FAULT, 0, 44, 0, 1,
            mk_res(wavhp_pkg::STATUS_OK, 33'h1_0000_0007, '1, '1, '1, '1, 32'h0001_0001));
    // every field at zero except a unit block align
    add_row(0, 16, 0, 0, 0, 1, 0, NO_FAULT, 0, 44, 0, 1,
            mk_res(wavhp_pkg::STATUS_OK, 8, 0, 0, 0, 1, 0));
    // largest sample count, then trailing bytes that must be dropped
    add_row(100, 16, 3, 1, 96000, 1, '1, NO_FAULT, 0, 52, 2, 1,
            mk_res(wavhp_pkg::STATUS_OK, 108, 3, 1, 96000, 1, '1));
    // zero block align
    add_row(36, 16, 1, 2, 8000, 0, 1234, NO_FAULT, 0, 44, 0, 1,
            mk_res(wavhp_pkg::STATUS_ZERO_ALIGN, 44, 1, 2, 8000, 0, 0));
    // riff tag broken by a zero byte, size not known yet
    add_row(36, 16, 1, 2, 8000, 4, 64, 0, 8'h00, 44, 0, 1,
            mk_res(wavhp_pkg::STATUS_NOT_WAV, 0, 0, 0, 0, 0, 0));
    // riff tag with a lower-case last letter, file cut right after it
    add_row(36, 16, 1, 2, 8000, 4, 64, 3, 8'h66, 4, 0, 1,
            mk_res(wavhp_pkg::STATUS_NOT_WAV, 0, 0, 0, 0, 0, 0));
    // wave tag broken
    add_row(32'h1000, 16, 1, 2, 8000, 4, 64, 8, 8'h00, 20, 0, 1,
            mk_res(wavhp_pkg::STATUS_NOT_WAV, 33'h1008, 0, 0, 0, 0, 0));
    // fmt tag broken in its trailing space
    add_row(36, 16, 1, 2, 8000, 4, 64, 15, 8'h00, 20, 0, 1,
            mk_res(wavhp_pkg::STATUS_CORRUPTED, 44, 0, 0, 0, 0, 0));
    // fmt chunk size of an extended header
    add_row(36, 18, 1, 2, 8000, 4, 64, NO_FAULT, 0, 20, 0, 1,
            mk_res(wavhp_pkg::STATUS_CORRUPTED, 44, 0, 0, 0, 0, 0));
    // fmt chunk size wrong only in its top byte
    add_row(36, 32'h1000_0010, 1, 2, 8000, 4, 64, NO_FAULT, 0, 20, 0, 1,
            mk_res(wavhp_pkg::STATUS_CORRUPTED, 44, 0, 0, 0, 0, 0));
    // data tag broken, format fields already captured
    add_row(36, 16, 1, 2, 22050, 4, 64, 36, 8'h00, 44, 0, 1,
            mk_res(wavhp_pkg::STATUS_CORRUPTED, 44, 1, 2, 22050, 4, 0));
    // short files, abandoned by the next first byte
    add_row(36, 16, 1, 2, 8000, 4, 64, NO_FAULT, 0, 20, 0, 0, '0);
    add_row(36, 16, 1, 2, 8000, 4, 64, NO_FAULT, 0, 43, 0, 0, '0);
    // odd sizes, left to the mirror
    add_row(32'h1234_5678, 16, 16'hFFFE, 6, 8000, 6, 32'h00AB_CDEF, NO_FAULT, 0, 44, 0, 0, '0);
    // damage inside the skipped byte rate and bit depth fields does not matter
    add_row(36, 16, 1, 2, 48000, 3, 32'h0001_0000, 29, 8'hFF, 44, 0, 0, '0);
    add_row(36, 16, 1, 2, 48000, 5, 32'hFFFF_FFFE, 35, 8'hA5, 44, 0, 0, '0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (hdr_table[i]) send_file(hdr_table[i]);

    // block the output for a long stretch while broken files keep coming, so
    // the result queue fills and the input stalls
    wait_drained();
    idle_on = 1'b0;
    hold_req = 1'b1;
    repeat (16) begin
      c = rand_case();
      c.bad_pos = 1;
      c.bad_val = 8'h00;
      c.len = 4;
      c.junk = 0;
      send_file(c);
    end
    // sender rests until every header is back
    wait_drained();

    // random files: mostly well formed, some damaged, short or pure noise,
    // with a run near the start where neither side idles
    file_no = 0;
    while (items_sent < ITEMS_TARGET) begin
      idle_on = !(file_no >= 1 && file_no < 4);
      if ($urandom_range(19) == 0) wait_drained();
      if ($urandom_range(99) < 8) begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom), $urandom_range(3) == 0);
      end else begin
        send_file(rand_case());
      end
      file_no++;
    end

    // let the last results out, then a quiet tail for strays
    wait_drained();
    repeat (100) @(posedge clk);
    if (fault_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
